// ===== design/grbf_pkg.sv =====
// grbf_pkg: shared types and fixed-point constants for the gaussian rbf activation
// used by gaussian_rbf_activation and grbf_checker; no dependencies
`default_nettype none

package grbf_pkg;

  // field widths of one transaction
  localparam int IN_BITS  = 16;
  localparam int OUT_BITS = 16;

  // squared operands, ratio fraction bits and the tiny-result limit on floor(x^2/w^2)
  localparam int SQ_BITS    = 2 * IN_BITS;
  localparam int FRAC_BITS  = 16;
  localparam int FRAC_SHIFT = FRAC_BITS - 1;
  localparam int TINY_RATIO = 2 * OUT_BITS + 2;
  localparam int QUO_BITS   = $clog2(TINY_RATIO << FRAC_SHIFT);

  // exp table entries are Q0.30, one more bit to hold exactly 1.0
  localparam int ENTRY_BITS = 31;
  localparam int LOG2E_BITS = 31;

  localparam logic [LOG2E_BITS-1:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0]           LN2_Q30   = 30'd744261118;

  typedef struct packed {
    logic signed [IN_BITS-1:0] net_input;
    logic        [IN_BITS-1:0] width;
  } grbf_in_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] activation;
    logic                width_error;
  } grbf_out_t;

endpackage

`default_nettype wire

// ===== design/gaussian_rbf_activation.sv =====
// gaussian_rbf_activation: pipelined exp(-x^2/(2w^2)) activation, Q8.8 in, Q0.16 out
// depends on grbf_pkg
`default_nettype none

// Gaussian radial basis activation. Every transaction carries a signed Q8.8 value x and
// an unsigned Q8.8 width w; the result is exp(-x^2/(2w^2)) as unsigned Q0.16, with 1.0
// saturated to 0xFFFF and anything below one LSB flushed to 0. A width of zero returns
// activation 0 with width_error set. The ratio x^2/(2w^2) is formed by a radix-2
// restoring divider in Q5.16, scaled by log2(e), split into integer and fraction, and
// the fraction indexes a table of 2^(-i/EXP_TABLE_DEPTH) with linear interpolation; the
// integer part is applied as a right shift. Throughput is one transaction per clock
// while the skid entry is empty. The divider resolves one quotient bit per pipeline
// stage (21 stages). A stall on the output freezes the pipeline only after a one-entry
// skid register has filled, so in_stall_o is a registered signal and an item is still
// taken in the first stalled cycle. The table is built at elaboration from
// EXP_TABLE_DEPTH and read as constant logic at two adjacent entries.
module gaussian_rbf_activation
  import grbf_pkg::*;
#(
  parameter int EXP_TABLE_DEPTH = 64
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire grbf_in_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output grbf_out_t      out_data_o
);

  // derived widths
  localparam int TW        = QUO_BITS + 1;                 // log2 domain exponent
  localparam int NFW       = TW - FRAC_BITS;               // integer part of exponent
  localparam int NW        = $clog2(OUT_BITS + 1);         // exponent kept after range check
  localparam int IW        = $clog2(EXP_TABLE_DEPTH + 1);  // table index
  localparam int PW        = FRAC_BITS + IW;               // scaled table position
  localparam int BIG_BITS  = SQ_BITS + $clog2(TINY_RATIO + 1);
  localparam int DVD_BITS  = SQ_BITS + FRAC_SHIFT;
  localparam int INIT_SHIFT = QUO_BITS - FRAC_SHIFT;
  localparam int MPW       = QUO_BITS + LOG2E_BITS;
  localparam int DPW       = ENTRY_BITS + FRAC_BITS;
  localparam int VS_BITS   = ENTRY_BITS + 2;               // value as Q0.32
  localparam int Q_POINT   = ENTRY_BITS + 1;               // fraction bits of that value
  localparam int SHW       = $clog2(Q_POINT + 1);
  localparam int TAYLOR_TERMS = 20;

  // exp table, 2^(-i/EXP_TABLE_DEPTH) in Q0.30, built by a truncated Taylor series
  typedef logic [ENTRY_BITS-1:0] lut_t [EXP_TABLE_DEPTH+1];

  function automatic lut_t build_lut();
    lut_t        lut;
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
      y    = (64'(i) * 64'(LN2_Q30)) / EXP_TABLE_DEPTH;
      term = 64'(1) << (ENTRY_BITS - 1);
      pos  = term;
      neg  = '0;
      for (int k = 1; k <= TAYLOR_TERMS; k++) begin
        term = ((term * y) >> (ENTRY_BITS - 1)) / 64'(k);
        if (k[0]) begin
          neg = neg + term;
        end else begin
          pos = pos + term;
        end
      end
      lut[i] = (pos > neg) ? ENTRY_BITS'(pos - neg) : '0;
    end
    return lut;
  endfunction

  localparam lut_t EXP_LUT = build_lut();

  // stage payloads
  typedef struct packed {
    logic               err;
    logic [SQ_BITS-1:0] x2;
    logic [SQ_BITS-1:0] w2;
  } sq_t;

  typedef struct packed {
    logic                zero;
    logic                err;
    logic [SQ_BITS-1:0]  rem;
    logic [SQ_BITS-1:0]  w2;
    logic [QUO_BITS-1:0] dlo;   // low dividend bits still to shift in
    logic [QUO_BITS-1:0] quo;
  } div_t;

  typedef struct packed {
    logic          zero;
    logic          err;
    logic [TW-1:0] t;
  } lg_t;

  typedef struct packed {
    logic                 zero;
    logic                 err;
    logic [IW-1:0]        idx;
    logic [FRAC_BITS-1:0] wt;
    logic [NW-1:0]        n;
  } ix_t;

  typedef struct packed {
    logic                  zero;
    logic                  err;
    logic [ENTRY_BITS-1:0] a;
    logic [ENTRY_BITS-1:0] b;
    logic [FRAC_BITS-1:0]  wt;
    logic [NW-1:0]         n;
  } lu_t;

  typedef struct packed {
    logic                  zero;
    logic                  err;
    logic                  ge;
    logic [ENTRY_BITS-1:0] a;
    logic [ENTRY_BITS-1:0] dq;
    logic [NW-1:0]         n;
  } ip_t;

  // pipeline advance: the whole pipeline holds only while the skid entry is occupied
  logic pipe_en;
  logic skid_v_q;
  logic out_v_q;
  grbf_out_t out_q;
  grbf_out_t skid_q;

  assign pipe_en    = !skid_v_q;
  assign in_stall_o = skid_v_q;

  // stage 1: magnitude and squares, zero-width detect
  logic [IN_BITS-1:0] x_raw;
  logic [IN_BITS-1:0] x_mag;
  sq_t sq_d;
  sq_t sq_q;
  logic sq_v_q;

  assign x_raw = in_data_i.net_input;
  assign x_mag = x_raw[IN_BITS-1] ? (~x_raw + 1'b1) : x_raw;

  always_comb begin
    sq_d.err = (in_data_i.width == '0);
    sq_d.x2  = SQ_BITS'(x_mag) * SQ_BITS'(x_mag);
    sq_d.w2  = SQ_BITS'(in_data_i.width) * SQ_BITS'(in_data_i.width);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q <= 1'b0;
    end else if (pipe_en) begin
      sq_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      sq_q <= sq_d;
    end
  end

  // stage 2: tiny-result check and divider setup
  // the quotient fits QUO_BITS whenever x^2 < TINY_RATIO * w^2, so the upper dividend
  // bits seed the partial remainder directly
  logic [BIG_BITS-1:0] big_lim;
  logic                big;
  logic [DVD_BITS-1:0] dvd;
  div_t dv0_d;
  div_t dv_q   [QUO_BITS+1];
  logic dv_v_q [QUO_BITS+1];

  always_comb begin
    big_lim    = BIG_BITS'(sq_q.w2) * BIG_BITS'(TINY_RATIO);
    big        = (BIG_BITS'(sq_q.x2) >= big_lim);
    dvd        = DVD_BITS'(sq_q.x2) << FRAC_SHIFT;
    dv0_d.zero = sq_q.err | big;
    dv0_d.err  = sq_q.err;
    dv0_d.rem  = SQ_BITS'(sq_q.x2 >> INIT_SHIFT);
    dv0_d.w2   = sq_q.w2;
    dv0_d.dlo  = dvd[QUO_BITS-1:0];
    dv0_d.quo  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else if (pipe_en) begin
      dv_v_q[0] <= sq_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      dv_q[0] <= dv0_d;
    end
  end

  // divider: one restoring step, one quotient bit, per stage
  for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
    logic [SQ_BITS:0] trial;
    logic             take;
    div_t             step_d;

    always_comb begin
      trial       = {dv_q[k].rem, dv_q[k].dlo[QUO_BITS-1]};
      take        = (trial >= {1'b0, dv_q[k].w2});
      step_d      = dv_q[k];
      step_d.rem  = take ? SQ_BITS'(trial - {1'b0, dv_q[k].w2}) : trial[SQ_BITS-1:0];
      step_d.dlo  = dv_q[k].dlo << 1;
      step_d.quo  = {dv_q[k].quo[QUO_BITS-2:0], take};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[k+1] <= 1'b0;
      end else if (pipe_en) begin
        dv_v_q[k+1] <= dv_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (pipe_en) begin
        dv_q[k+1] <= step_d;
      end
    end
  end

  // convert the Q5.16 ratio into a power of two: t = r * log2(e)
  logic [MPW-1:0] lg_prod;
  lg_t lg_d;
  lg_t lg_q;
  logic lg_v_q;

  always_comb begin
    lg_prod   = MPW'(dv_q[QUO_BITS].quo) * MPW'(LOG2E_Q30);
    lg_d.zero = dv_q[QUO_BITS].zero;
    lg_d.err  = dv_q[QUO_BITS].err;
    lg_d.t    = lg_prod[MPW-1:ENTRY_BITS-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lg_v_q <= 1'b0;
    end else if (pipe_en) begin
      lg_v_q <= dv_v_q[QUO_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      lg_q <= lg_d;
    end
  end

  // split exponent, flush when the shift would clear every output bit, locate table entry
  logic [NFW-1:0] n_full;
  logic [PW-1:0]  pos;
  ix_t ix_d;
  ix_t ix_q;
  logic ix_v_q;

  always_comb begin
    n_full    = lg_q.t[TW-1:FRAC_BITS];
    pos       = PW'(lg_q.t[FRAC_BITS-1:0]) * PW'(EXP_TABLE_DEPTH);
    ix_d.zero = lg_q.zero | (n_full > NFW'(OUT_BITS));
    ix_d.err  = lg_q.err;
    ix_d.idx  = pos[PW-1:FRAC_BITS];
    ix_d.wt   = pos[FRAC_BITS-1:0];
    ix_d.n    = n_full[NW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ix_v_q <= 1'b0;
    end else if (pipe_en) begin
      ix_v_q <= lg_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      ix_q <= ix_d;
    end
  end

  // table read at the entry and its successor
  logic [IW-1:0] idx_nx;
  lu_t lu_d;
  lu_t lu_q;
  logic lu_v_q;

  assign idx_nx = ix_q.idx + IW'(1);

  always_comb begin
    lu_d.zero = ix_q.zero;
    lu_d.err  = ix_q.err;
    lu_d.a    = EXP_LUT[ix_q.idx];
    lu_d.b    = EXP_LUT[idx_nx];
    lu_d.wt   = ix_q.wt;
    lu_d.n    = ix_q.n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lu_v_q <= 1'b0;
    end else if (pipe_en) begin
      lu_v_q <= ix_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      lu_q <= lu_d;
    end
  end

  // interpolation weight times the entry difference
  logic [ENTRY_BITS-1:0] diff;
  logic [DPW-1:0]        dprod;
  ip_t ip_d;
  ip_t ip_q;
  logic ip_v_q;

  always_comb begin
    ip_d.ge   = (lu_q.a >= lu_q.b);
    diff      = ip_d.ge ? (lu_q.a - lu_q.b) : (lu_q.b - lu_q.a);
    dprod     = DPW'(diff) * DPW'(lu_q.wt);
    ip_d.zero = lu_q.zero;
    ip_d.err  = lu_q.err;
    ip_d.a    = lu_q.a;
    ip_d.dq   = dprod[DPW-1:FRAC_BITS];
    ip_d.n    = lu_q.n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ip_v_q <= 1'b0;
    end else if (pipe_en) begin
      ip_v_q <= lu_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      ip_q <= ip_d;
    end
  end

  // final value, shift by the integer exponent, saturate at the top code
  logic [ENTRY_BITS-1:0] v;
  logic [SHW-1:0]        sh;
  logic [VS_BITS-1:0]    act;
  grbf_out_t             res;

  always_comb begin
    v   = ip_q.ge ? (ip_q.a - ip_q.dq) : (ip_q.a + ip_q.dq);
    sh  = SHW'(Q_POINT - OUT_BITS) + SHW'(ip_q.n);
    act = {v, 2'b00} >> sh;
    res.width_error = ip_q.err;
    if (ip_q.zero) begin
      res.activation = '0;
    end else if (|act[VS_BITS-1:OUT_BITS]) begin
      res.activation = '1;
    end else begin
      res.activation = act[OUT_BITS-1:0];
    end
  end

  // output register plus one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || !out_stall_i) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= ip_v_q;
      end
    end else if (ip_v_q && pipe_en) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || !out_stall_i) begin
      out_q <= skid_v_q ? skid_q : res;
    end
    if (out_v_q && out_stall_i && !skid_v_q) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== design/grbf_checker.sv =====
// grbf_checker: port-level assertions for gaussian_rbf_activation, attached by bind
// depends on grbf_pkg
`default_nettype none

module grbf_checker
  import grbf_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_stall_o,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire grbf_out_t out_data_o
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output transaction changed");

  // zero width always reports a zero activation
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.width_error |-> out_data_o.activation == '0)
    else $error("width error with nonzero activation");

  // input back-pressure only follows a stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stall without output stall");

  // the skid entry is only occupied behind a valid output
  a_stall_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no output pending");

  // the skid entry drains as soon as the output moves
  a_stall_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && !out_stall_i |=> !in_stall_o)
    else $error("input stall held after output drained");

endmodule

bind gaussian_rbf_activation grbf_checker u_grbf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
